### hdl/sfcs_pkg.sv
// Shared codes, command bytes and result type for the SPI flash command sequencer.
package sfcs_pkg;

  localparam logic [2:0] OP_READ_ID    = 3'd0;
  localparam logic [2:0] OP_READ_DATA  = 3'd1;
  localparam logic [2:0] OP_ERASE      = 3'd2;
  localparam logic [2:0] OP_PAGE_WRITE = 3'd3;
  localparam logic [2:0] OP_WRITE_BYTE = 3'd4;
  localparam logic [2:0] OP_BUS_BYTE   = 3'd6;

  localparam logic [2:0] ACT_SHIFT    = 3'd0;
  localparam logic [2:0] ACT_SEL_LOW  = 3'd1;
  localparam logic [2:0] ACT_SEL_HIGH = 3'd2;
  localparam logic [2:0] ACT_DELIVER  = 3'd3;
  localparam logic [2:0] ACT_DONE     = 3'd4;
  localparam logic [2:0] ACT_NEED     = 3'd5;
  localparam logic [2:0] ACT_REJECT   = 3'd6;

  localparam logic [1:0] REQ_ID    = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_ERASE = 2'd2;
  localparam logic [1:0] REQ_WRITE = 2'd3;

  localparam logic [7:0] CMD_READ_ID   = 8'h90;
  localparam logic [7:0] CMD_READ      = 8'h03;
  localparam logic [7:0] CMD_ERASE     = 8'h20;
  localparam logic [7:0] CMD_PROGRAM   = 8'h02;
  localparam logic [7:0] CMD_STATUS    = 8'h05;
  localparam logic [7:0] CMD_WR_ENABLE = 8'h06;
  localparam logic [7:0] CMD_WR_DISABLE = 8'h04;
  localparam logic [7:0] DUMMY_READ    = 8'hFF;
  localparam logic [7:0] DUMMY_POLL    = 8'h00;
  localparam logic [7:0] ID_LENGTH     = 8'd2;

  typedef struct packed {
    logic       last;
    logic [7:0] rx_byte;
    logic [7:0] tx_byte;
    logic [2:0] action;
  } result_t;

endpackage

### hdl/spi_flash_command_sequencer.sv
// Top level of the SPI flash command sequencer with its result queue.

// The sequencer takes one request per clock while at most one result is queued
// and reacts to it in the same cycle, writing one to three results into a
// four-entry result queue. The queue drains one result per clock while m_tready
// is high; a request is taken whenever at most one result is still queued.
// Single-result requests therefore flow at one per cycle while m_tready is high.
module spi_flash_command_sequencer
  import sfcs_pkg::*;
#(
  parameter int PAGE_LIMIT = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // address[23:0], length[31:24], data_byte[39:32]
  input  logic [2:0]  s_tuser,   // operation[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // tx_byte[7:0], rx_byte[15:8]
  output logic [2:0]  m_tuser,   // action[2:0]
  output logic        m_tlast
);

  localparam logic [8:0] PageLimitW = 9'(PAGE_LIMIT);

  typedef enum logic [3:0] {
    PH_IDLE, PH_WEN, PH_CMD, PH_A2, PH_A1, PH_A0, PH_RD,
    PH_WDATA, PH_WBYTE, PH_STCMD, PH_POLL, PH_WDIS
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  current_request, current_request_next;
  logic [23:0] flash_address, flash_address_next;
  logic [7:0]  bytes_left, bytes_left_next;

  result_t     queue [4];
  logic [1:0]  head, tail;
  logic [2:0]  count;

  logic [2:0]  operation;
  logic [23:0] address;
  logic [7:0]  length;
  logic [7:0]  data_byte;
  logic        accept, pop, ok;
  logic [1:0]  n;
  logic [7:0]  left_dec;
  result_t     res [3];

  assign operation = s_tuser;
  assign address   = s_tdata[23:0];
  assign length    = s_tdata[31:24];
  assign data_byte = s_tdata[39:32];

  assign s_tready = (count <= 3'd1);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = (count != 3'd0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = {queue[head].rx_byte, queue[head].tx_byte};
  assign m_tuser  = queue[head].action;
  assign m_tlast  = queue[head].last;
  assign left_dec = bytes_left - 8'd1;

  always_comb begin
    phase_next           = phase;
    current_request_next = current_request;
    flash_address_next   = flash_address;
    bytes_left_next      = bytes_left;
    ok = 1'b1;
    n  = 2'd1;
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end
    unique case (phase)
      PH_IDLE: begin
        if (operation <= OP_PAGE_WRITE) begin
          current_request_next = operation[1:0];
          res[0].action = ACT_SEL_LOW;
          res[1].action = ACT_SHIFT;
          n = 2'd2;
          phase_next = PH_CMD;
          if (operation == OP_READ_ID) begin
            flash_address_next = '0;
            bytes_left_next    = ID_LENGTH;
            res[1].tx_byte     = CMD_READ_ID;
          end else if (operation == OP_READ_DATA) begin
            flash_address_next = address;
            bytes_left_next    = length;
            res[1].tx_byte     = CMD_READ;
          end else begin
            flash_address_next = address;
            if (operation == OP_ERASE) begin
              bytes_left_next = '0;
            end else if ({1'b0, length} > PageLimitW) begin
              bytes_left_next = PageLimitW[7:0];
            end else begin
              bytes_left_next = length;
            end
            res[1].tx_byte = CMD_WR_ENABLE;
            phase_next     = PH_WEN;
          end
        end else begin
          ok = 1'b0;
        end
      end
      PH_WDATA: begin
        if (operation == OP_WRITE_BYTE) begin
          res[0].action   = ACT_SHIFT;
          res[0].tx_byte  = data_byte;
          bytes_left_next = left_dec;
          phase_next      = PH_WBYTE;
        end else begin
          ok = 1'b0;
        end
      end
      default: begin
        if (operation != OP_BUS_BYTE) begin
          ok = 1'b0;
        end else begin
          unique case (phase)
            PH_WEN: begin
              res[0].action  = ACT_SEL_HIGH;
              res[1].action  = ACT_SEL_LOW;
              res[2].action  = ACT_SHIFT;
              res[2].tx_byte = (current_request == REQ_ERASE) ? CMD_ERASE : CMD_PROGRAM;
              n = 2'd3;
              phase_next = PH_CMD;
            end
            PH_CMD: begin
              res[0].tx_byte = flash_address[23:16];
              phase_next = PH_A2;
            end
            PH_A2: begin
              res[0].tx_byte = flash_address[15:8];
              phase_next = PH_A1;
            end
            PH_A1: begin
              res[0].tx_byte = flash_address[7:0];
              phase_next = PH_A0;
            end
            PH_A0, PH_WBYTE: begin
              if (current_request == REQ_ERASE ||
                  (current_request == REQ_WRITE && bytes_left == 8'd0)) begin
                res[0].action  = ACT_SEL_HIGH;
                res[1].action  = ACT_SEL_LOW;
                res[2].action  = ACT_SHIFT;
                res[2].tx_byte = CMD_STATUS;
                n = 2'd3;
                phase_next = PH_STCMD;
              end else if (current_request == REQ_WRITE) begin
                res[0].action = ACT_NEED;
                phase_next = PH_WDATA;
              end else if (bytes_left != 8'd0) begin
                res[0].tx_byte = DUMMY_READ;
                phase_next = PH_RD;
              end else begin
                res[0].action = ACT_SEL_HIGH;
                res[1].action = ACT_DONE;
                n = 2'd2;
                phase_next = PH_IDLE;
              end
            end
            PH_RD: begin
              res[0].action   = ACT_DELIVER;
              res[0].rx_byte  = data_byte;
              bytes_left_next = left_dec;
              n = 2'd2;
              if (left_dec != 8'd0) begin
                res[1].tx_byte = DUMMY_READ;
              end else begin
                res[1].action = ACT_SEL_HIGH;
                res[2].action = ACT_DONE;
                n = 2'd3;
                phase_next = PH_IDLE;
              end
            end
            PH_STCMD: begin
              res[0].tx_byte = DUMMY_POLL;
              phase_next = PH_POLL;
            end
            PH_POLL: begin
              if (data_byte[0]) begin
                res[0].tx_byte = DUMMY_POLL;
              end else begin
                res[0].action  = ACT_SEL_HIGH;
                res[1].action  = ACT_SEL_LOW;
                res[2].action  = ACT_SHIFT;
                res[2].tx_byte = CMD_WR_DISABLE;
                n = 2'd3;
                phase_next = PH_WDIS;
              end
            end
            PH_WDIS: begin
              res[0].action = ACT_SEL_HIGH;
              res[1].action = ACT_DONE;
              n = 2'd2;
              phase_next = PH_IDLE;
            end
            default: begin
              ok = 1'b0;
            end
          endcase
        end
      end
    endcase
    if (!ok) begin
      phase_next           = phase;
      current_request_next = current_request;
      flash_address_next   = flash_address;
      bytes_left_next      = bytes_left;
      n = 2'd1;
      res[0] = '0;
      res[0].action = ACT_REJECT;
    end
    res[n - 2'd1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      current_request <= '0;
      flash_address   <= '0;
      bytes_left      <= '0;
      head            <= '0;
      tail            <= '0;
      count           <= '0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        current_request <= current_request_next;
        flash_address   <= flash_address_next;
        bytes_left      <= bytes_left_next;
        tail            <= tail + n;
      end
      if (pop) begin
        head <= head + 2'd1;
      end
      count <= count + (accept ? {1'b0, n} : 3'd0) - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < n) begin
          queue[tail + 2'(i)] <= res[i];
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("Result queue count exceeds its depth.");

  assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_IDLE && operation <= OP_PAGE_WRITE |=> phase != PH_IDLE)
    else $error("A new request did not leave the idle phase.");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("A queued result vanished before it was taken.");

  assert property (@(posedge clk) disable iff (rst)
    accept && phase != PH_IDLE && operation != OP_BUS_BYTE && operation != OP_WRITE_BYTE
    |=> $stable(phase))
    else $error("A rejected request changed the phase.");

endmodule
